// File: rtl/srk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srk_pkg
// Shared types and constants of the scored top-K ranker.
// ----------------------------------------------------------------------------
package srk_pkg;

  localparam int MaxRanked = 8;
  localparam int IdxW      = (MaxRanked > 1) ? $clog2(MaxRanked) : 1;
  localparam int CntW      = $clog2(MaxRanked + 1);

  localparam int ScoreW    = 13;
  localparam int IdW       = 16;
  localparam int TimeW     = 40;
  localparam int RankW     = 3;
  localparam int InDataW   = 120;
  localparam int OutDataW  = 32;

  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [TimeW-1:0] WeekSeconds = TimeW'(7 * 24 * 60 * 60);

  localparam logic [2:0] TypeProfile    = 3'd1;
  localparam logic [2:0] TypeCorrection = 3'd2;

  typedef enum logic [1:0] {
    FuncOffer = 2'd0,
    FuncRead  = 2'd1,
    FuncClear = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CfgLimit = 2'd0,
    CfgTime  = 2'd1,
    CfgQuery = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdRead   = 2'd1,
    CmdClear  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [IdW-1:0]      id;
    logic [ScoreW-1:0]   score;
  } cmd_t;

  typedef enum logic {
    BackIdle = 1'b0,
    BackRead = 1'b1
  } back_state_e;

endpackage
`default_nettype wire

// File: rtl/scored_top_k_ranker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scored_top_k_ranker
// Scores offered records and keeps the best ones in a ranked list.
// ----------------------------------------------------------------------------
// Channels: the slave stream carries one item per handshake; tuser selects
// offer, read-out or clear. Offers are scored in the front and, if positive
// and not expired, queued for the ranked list; read-outs and clears are
// queued as they are. The master stream returns ranked entries, rank 0
// first, with tlast on the final one; an empty list returns one item with
// tuser low. The cfg channel writes limit, current time and query flag and
// is always ready; write it only while the block is idle.
// Throughput: the front takes one item per cycle while the four-entry
// command queue has room. The back retires an offer (through the
// compare-and-shift row) or a clear per cycle while no read-out holds it;
// a read-out holds it until each listed entry (at least one) is emitted.
// A read-out item reaches tvalid through the queue and then the output register.
// Reset empties the list and queue and sets limit 8, time 0, no query.
// A stalled receiver holds the output register; the back then stops at the
// next read-out and the queue fills until the slave side deasserts tready.
// ----------------------------------------------------------------------------
module scored_top_k_ranker import srk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [TimeW-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // record_id, importance, overlap, contains_query, record_type,
  // creation time, expiry time, zero pad
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  input  wire logic [1:0]           s_axis_tuser,   // func
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,   // rank, out_id, out_score
  output logic                      m_axis_tuser,   // valid_res
  output logic                      m_axis_tlast    // last
);

  logic            q_full, q_empty, push, pop;
  cmd_t            cmd, head;
  logic [CntW-1:0] limit;

  srk_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd),
    .limit_o       (limit)
  );

  srk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  srk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .limit_i       (limit),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/srk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srk_front
// Holds the configuration, accepts items, scores offers and queues commands.
// ----------------------------------------------------------------------------
module srk_front import srk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [TimeW-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  input  wire logic [1:0]           s_axis_tuser,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o,
  output logic [CntW-1:0]           limit_o
);

  logic [CntW-1:0]   lim_q, lim_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic              query_q, query_d;

  logic [IdW-1:0]    rec_id;
  logic [7:0]        imp, ovl;
  logic              contains;
  logic [2:0]        rtype;
  logic [TimeW-1:0]  created, expires, age;
  logic              recent, expired, accept;
  logic [ScoreW-1:0] ovl20, score;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && !q_full_i;

  always_comb begin
    lim_d   = lim_q;
    time_d  = time_q;
    query_d = query_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLimit: begin
          // clamp the limit into 1..MaxRanked once, on write
          if (cfg_data_i[3:0] == 4'd0) lim_d = CntW'(1);
          else if (int'(cfg_data_i[3:0]) > MaxRanked) lim_d = CntW'(MaxRanked);
          else lim_d = CntW'(cfg_data_i[3:0]);
        end
        CfgTime:  time_d  = cfg_data_i;
        CfgQuery: query_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q   <= CntW'(MaxRanked);
      time_q  <= '0;
      query_q <= 1'b0;
    end else begin
      lim_q   <= lim_d;
      time_q  <= time_d;
      query_q <= query_d;
    end
  end

  assign limit_o  = lim_q;

  assign rec_id   = s_axis_tdata[15:0];
  assign imp      = s_axis_tdata[23:16];
  assign ovl      = s_axis_tdata[31:24];
  assign contains = s_axis_tdata[32];
  assign rtype    = s_axis_tdata[35:33];
  assign created  = s_axis_tdata[75:36];
  assign expires  = s_axis_tdata[115:76];

  assign age      = time_q - created;
  assign recent   = (created != '0) && (time_q >= created) && (age < WeekSeconds);
  assign expired  = (expires != '0) && (time_q >= expires);
  assign ovl20    = (ScoreW'(ovl) << 4) + (ScoreW'(ovl) << 2);

  always_comb begin
    if (!query_q) begin
      score = ScoreW'(imp);
    end else if (ovl == 8'd0 && rtype != TypeProfile) begin
      score = '0;
    end else begin
      score = ScoreW'(imp) + ovl20
            + (contains ? ScoreW'(100) : ScoreW'(0))
            + ((rtype == TypeCorrection) ? ScoreW'(15) : ScoreW'(0))
            + (recent ? ScoreW'(10) : ScoreW'(0));
    end
  end

  always_comb begin
    push_o    = 1'b0;
    cmd_o.op  = CmdInsert;
    cmd_o.id  = rec_id;
    cmd_o.score = score;
    case (func_e'(s_axis_tuser))
      FuncOffer: push_o = accept && !expired && (score != '0);
      FuncRead: begin
        cmd_o.op = CmdRead;
        push_o   = accept;
      end
      FuncClear: begin
        cmd_o.op = CmdClear;
        push_o   = accept;
      end
      default: push_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/srk_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srk_queue
// Short command queue between the front and the ranked list.
// ----------------------------------------------------------------------------
module srk_queue import srk_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t                mem_q [QDepth];
  logic [QPtrW-1:0]    wr_q, rd_q;
  logic [QPtrW:0]      cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/srk_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srk_back
// Ranked list with a compare-and-shift row, read-out sequencer and
// output register.
// ----------------------------------------------------------------------------
module srk_back import srk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire cmd_t                  head_i,
  output logic                       pop_o,
  input  wire logic [CntW-1:0]       limit_i,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OutDataW-1:0]        m_axis_tdata,   // rank, out_id, out_score
  output logic                       m_axis_tuser,   // valid_res
  output logic                       m_axis_tlast
);

  back_state_e       state_q, state_d;
  logic [ScoreW-1:0] score_q [MaxRanked];
  logic [IdW-1:0]    id_q    [MaxRanked];
  logic [ScoreW-1:0] score_d [MaxRanked];
  logic [IdW-1:0]    id_d    [MaxRanked];
  logic [CntW-1:0]   count_q, eff_cnt, ins_cnt;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [MaxRanked-1:0] take;

  logic              oval_q;
  logic              ores_q, olast_q;
  logic [RankW-1:0]  orank_q;
  logic [IdW-1:0]    oid_q;
  logic [ScoreW-1:0] oscore_q;

  logic              out_free, read_last, do_ins, do_clr, emit;
  logic              e_res, e_last;
  logic [RankW-1:0]  e_rank;
  logic [IdW-1:0]    e_id;
  logic [ScoreW-1:0] e_score;

  assign out_free  = !oval_q || m_axis_tready;
  assign read_last = (CntW'(ptr_q) + CntW'(1)) == count_q;

  // drop entries beyond a lowered limit before inserting
  assign eff_cnt = (count_q > limit_i) ? limit_i : count_q;
  assign ins_cnt = (eff_cnt < limit_i) ? eff_cnt + CntW'(1) : eff_cnt;

  for (genvar g = 0; g < MaxRanked; g++) begin : g_slot
    assign take[g] = (CntW'(g) < limit_i) &&
                     ((CntW'(g) < eff_cnt) ? (head_i.score > score_q[g])
                                           : (CntW'(g) == eff_cnt));
    if (g == 0) begin : g_first
      assign score_d[g] = take[g] ? head_i.score : score_q[g];
      assign id_d[g]    = take[g] ? head_i.id    : id_q[g];
    end else begin : g_rest
      assign score_d[g] = !take[g] ? score_q[g] :
                          (take[g-1] ? score_q[g-1] : head_i.score);
      assign id_d[g]    = !take[g] ? id_q[g] :
                          (take[g-1] ? id_q[g-1] : head_i.id);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (!empty_i && head_i.op == CmdRead && out_free && count_q > CntW'(1))
          state_d = BackRead;
      end
      BackRead: begin
        if (out_free && read_last) state_d = BackIdle;
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    do_ins  = 1'b0;
    do_clr  = 1'b0;
    emit    = 1'b0;
    e_res   = 1'b1;
    e_rank  = RankW'(ptr_q);
    e_id    = id_q[ptr_q];
    e_score = score_q[ptr_q];
    e_last  = read_last;
    ptr_d   = ptr_q;
    case (state_q)
      BackIdle: begin
        if (!empty_i) begin
          case (head_i.op)
            CmdInsert: begin
              pop_o  = 1'b1;
              do_ins = 1'b1;
            end
            CmdClear: begin
              pop_o  = 1'b1;
              do_clr = 1'b1;
            end
            CmdRead: begin
              if (out_free) begin
                pop_o  = 1'b1;
                emit   = 1'b1;
                e_rank = '0;
                if (count_q == '0) begin
                  e_res   = 1'b0;
                  e_id    = '0;
                  e_score = '0;
                  e_last  = 1'b1;
                end else begin
                  e_id    = id_q[0];
                  e_score = score_q[0];
                  e_last  = (count_q == CntW'(1));
                  ptr_d   = IdxW'(1);
                end
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BackRead: begin
        if (out_free) begin
          emit  = 1'b1;
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      count_q <= '0;
      ptr_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (do_clr) count_q <= '0;
      else if (do_ins) count_q <= ins_cnt;
      if (emit) oval_q <= 1'b1;
      else if (m_axis_tready) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 0; i < MaxRanked; i++) begin
        score_q[i] <= score_d[i];
        id_q[i]    <= id_d[i];
      end
    end
    if (emit) begin
      ores_q   <= e_res;
      orank_q  <= e_rank;
      oid_q    <= e_id;
      oscore_q <= e_score;
      olast_q  <= e_last;
    end
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {oscore_q, oid_q, orank_q};
  assign m_axis_tuser  = ores_q;
  assign m_axis_tlast  = olast_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxRanked))
    else $error("entry count above list size");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BackRead |-> CntW'(ptr_q) < count_q)
    else $error("read-out pointer past the list");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clr |=> count_q == '0)
    else $error("clear did not empty the list");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scored top-K ranker: offers, read-outs and
// clears go in on the slave stream, each read-out is predicted from a local
// copy of the ranked list and every returned entry is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import srk_pkg::*;

  localparam int             Depth           = 8;
  localparam int             DrainCycles     = 40;
  localparam int             DrainLimit      = 20000;
  localparam int             OverlapWeight   = 20;
  localparam int             ContainsBonus   = 100;
  localparam int             CorrectionBonus = 15;
  localparam int             RecentBonus     = 10;
  localparam logic [39:0]    WeekSecs        = 40'd604800;
  localparam logic [39:0]    T0              = 40'd1_000_000;
  localparam logic [39:0]    TimeMax         = 40'hFF_FFFF_FFFF;
  localparam logic [1:0]     FuncUnused      = 2'd3;
  localparam logic [2:0]     KindPlain       = 3'd0;
  localparam logic [2:0]     KindOther       = 3'd7;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] id;
    logic [7:0]  importance;
    logic [7:0]  overlap;
    logic        contains;
    logic [2:0]  kind;
    logic [39:0] created;
    logic [39:0] expires;
  } record_t;

  typedef struct packed {
    logic        vres;
    logic [2:0]  rank;
    logic [15:0] id;
    logic [12:0] score;
    logic        last;
  } entry_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CfgLimit;
  logic [TimeW-1:0]    cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic [1:0]          s_user = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_user;
  logic                m_last;

  // local copy of the ranked list and of the registers
  logic [12:0] kept_score [Depth];
  logic [15:0] kept_id    [Depth];
  int          kept_n    = 0;
  logic [3:0]  cfg_limit = 4'd8;
  logic [39:0] cfg_now   = '0;
  logic        cfg_query = 1'b0;

  entry_t readout_q [$];

  bit tx_idle   = 1'b1;
  bit rx_idle   = 1'b1;
  int hold_left = 0;
  int fail_count     = 0;
  int items_sent     = 0;
  int readouts_sent  = 0;
  int results_seen   = 0;
  int settings_count = 0;

  scored_top_k_ranker u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic int relevance(input record_t r);
    int s;
    if (!cfg_query) return int'(r.importance);
    if (r.overlap == 8'd0 && r.kind != TypeProfile) return 0;
    s = int'(r.importance) + OverlapWeight * int'(r.overlap);
    if (r.contains) s += ContainsBonus;
    if (r.kind == TypeCorrection) s += CorrectionBonus;
    if (r.created != '0 && cfg_now >= r.created && cfg_now - r.created < WeekSecs)
      s += RecentBonus;
    return s;
  endfunction

  // update the local list for one accepted item, queue any read-out entries
  function automatic void track_item(input record_t r);
    int     lim;
    int     pos;
    int     sc;
    entry_t e;
    case (r.func)
      FuncOffer: begin
        lim = (cfg_limit == 4'd0) ? 1 : (int'(cfg_limit) > Depth) ? Depth : int'(cfg_limit);
        if (r.expires != '0 && cfg_now >= r.expires) return;
        sc = relevance(r);
        if (sc == 0) return;
        if (kept_n > lim) kept_n = lim;
        if (kept_n == lim) begin
          if (sc <= kept_score[lim-1]) return;
          pos = lim - 1;
        end else begin
          pos = kept_n;
        end
        while (pos > 0 && sc > kept_score[pos-1]) begin
          kept_score[pos] = kept_score[pos-1];
          kept_id[pos]    = kept_id[pos-1];
          pos--;
        end
        kept_score[pos] = sc[12:0];
        kept_id[pos]    = r.id;
        if (kept_n < lim) kept_n++;
      end
      FuncRead: begin
        if (kept_n == 0) begin
          e = '0;
          e.last = 1'b1;
          readout_q.push_back(e);
        end
        for (int k = 0; k < kept_n; k++) begin
          e.vres  = 1'b1;
          e.rank  = k[2:0];
          e.id    = kept_id[k];
          e.score = kept_score[k];
          e.last  = (k == kept_n - 1);
          readout_q.push_back(e);
        end
      end
      FuncClear: kept_n = 0;
      default: ;
    endcase
  endfunction

  // offer one item; valid stays up after acceptance so back-to-back items
  // need no second assignment in the same step
  task automatic send_item(input record_t r);
    while (tx_idle && $urandom_range(0, 99) < 25) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= r.func;
    s_data  <= {4'd0, r.expires, r.created, r.kind, r.contains, r.overlap,
                r.importance, r.id};
    @(negedge clk);
    while (!s_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    track_item(r);
    items_sent++;
    if (r.func == FuncRead) readouts_sent++;
  endtask

  // wait for all pending entries, then let queued offers and clears retire
  task automatic drain();
    int n;
    s_valid <= 1'b0;
    n = 0;
    while (readout_q.size() != 0 && n < DrainLimit) begin
      @(posedge clk);
      n++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (readout_q.size() != 0) begin
      flag_error($sformatf("%0d expected entries never returned", readout_q.size()));
      readout_q.delete();
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    case (idx)
      CfgLimit: cfg_limit = val[3:0];
      CfgTime:  cfg_now   = val;
      CfgQuery: cfg_query = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [3:0] lim, input logic [39:0] now, input logic q);
    drain();
    write_reg(CfgLimit, {36'd0, lim});
    write_reg(CfgTime, now);
    write_reg(CfgQuery, {39'd0, q});
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  function automatic record_t control_item(input logic [1:0] func);
    record_t r;
    r = '{func: func, id: '0, importance: '0, overlap: '0, contains: 1'b0,
          kind: KindPlain, created: '0, expires: '0};
    return r;
  endfunction

  function automatic record_t offer_item(input logic [15:0] id, input logic [7:0] imp,
                                         input logic [7:0] ovl, input logic cq,
                                         input logic [2:0] kind, input logic [39:0] created,
                                         input logic [39:0] expires);
    record_t r;
    r = '{func: FuncOffer, id: id, importance: imp, overlap: ovl, contains: cq,
          kind: kind, created: created, expires: expires};
    return r;
  endfunction

  function automatic logic [39:0] rand_time();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  function automatic record_t random_record();
    record_t r;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 68)      r.func = FuncOffer;
    else if (pick < 84) r.func = FuncRead;
    else if (pick < 92) r.func = FuncClear;
    else                r.func = FuncUnused;
    r.id         = 16'($urandom());
    r.importance = 8'($urandom());
    r.overlap    = ($urandom_range(0, 99) < 20) ? 8'd0 : 8'($urandom());
    r.contains   = 1'($urandom());
    r.kind       = 3'($urandom());
    // cluster creation times around now to hit the one-week window
    pick = $urandom_range(0, 9);
    if (pick < 2)      r.created = '0;
    else if (pick < 7) r.created = cfg_now - 40'($urandom_range(0, 2 * 604800));
    else               r.created = rand_time();
    pick = $urandom_range(0, 9);
    if (pick < 4)      r.expires = '0;
    else if (pick < 6) r.expires = cfg_now + 40'($urandom_range(0, 2)) - 40'd1;
    else               r.expires = rand_time();
    return r;
  endfunction

  // compare each accepted entry; values are stable at the falling edge
  always @(negedge clk) begin : check_results
    entry_t got;
    entry_t want;
    if (rst_n && m_valid && m_ready) begin
      got = '{vres: m_user, rank: m_data[2:0], id: m_data[18:3],
              score: m_data[31:19], last: m_last};
      results_seen++;
      if (readout_q.size() == 0) begin
        flag_error($sformatf("unexpected entry valid=%0d rank=%0d id=%h score=%0d last=%0d",
                             got.vres, got.rank, got.id, got.score, got.last));
      end else begin
        want = readout_q.pop_front();
        if (got != want)
          flag_error($sformatf({"entry mismatch exp valid=%0d rank=%0d id=%h score=%0d ",
                                "last=%0d got valid=%0d rank=%0d id=%h score=%0d last=%0d"},
                               want.vres, want.rank, want.id, want.score, want.last,
                               got.vres, got.rank, got.id, got.score, got.last));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !(rx_idle && $urandom_range(0, 99) < 25);
    end
  end

  task automatic test_empty_and_ignored();
    send_item(control_item(FuncRead));
    send_item(control_item(FuncUnused));
    send_item(offer_item(16'h0001, 8'd0, 8'd0, 1'b0, KindPlain, '0, '0));
    send_item(offer_item(16'hFFFF, 8'd255, 8'hFF, 1'b1, KindOther, TimeMax, '0));
    send_item(offer_item(16'h0000, 8'd1, 8'd0, 1'b0, TypeProfile, '0, '0));
    send_item(offer_item(16'h1234, 8'd40, 8'd3, 1'b0, KindPlain, '0, 40'd5));
    send_item(control_item(FuncRead));
    send_item(control_item(FuncClear));
    send_item(control_item(FuncRead));
  endtask

  task automatic test_query_scoring();
    // limit above the list depth acts as the full depth
    set_config(4'd15, T0, 1'b1);
    send_item(offer_item(16'h0101, 8'd200, 8'd0, 1'b1, KindPlain, '0, '0));
    send_item(offer_item(16'h0102, 8'd5, 8'd0, 1'b0, TypeProfile, '0, '0));
    send_item(offer_item(16'h0103, 8'd255, 8'd255, 1'b1, TypeCorrection, T0 - 40'd1, '0));
    send_item(offer_item(16'h0104, 8'd10, 8'd1, 1'b0, KindPlain, T0 - WeekSecs, '0));
    send_item(offer_item(16'h0105, 8'd10, 8'd1, 1'b0, KindPlain, T0 - WeekSecs + 40'd1,
                         '0));
    send_item(offer_item(16'h0106, 8'd10, 8'd1, 1'b0, KindPlain, T0 + 40'd1, '0));
    send_item(offer_item(16'h0107, 8'd10, 8'd1, 1'b0, KindPlain, '0, '0));
    send_item(offer_item(16'h0108, 8'd100, 8'd5, 1'b1, KindPlain, '0, T0));
    send_item(offer_item(16'h0109, 8'd100, 8'd5, 1'b1, KindPlain, '0, T0 + 40'd1));
    send_item(offer_item(16'h010A, 8'd0, 8'd2, 1'b0, KindOther, TimeMax, TimeMax));
    send_item(offer_item(16'h010B, 8'd7, 8'd3, 1'b0, TypeProfile, '0, '0));
    send_item(offer_item(16'h010C, 8'd9, 8'd0, 1'b1, TypeCorrection, T0, '0));
    send_item(control_item(FuncRead));
  endtask

  task automatic test_limit_changes();
    // lowered limit: read-out still lists all, the next offer trims
    set_config(4'd2, T0, 1'b1);
    send_item(control_item(FuncRead));
    send_item(offer_item(16'h0201, 8'd20, 8'd1, 1'b0, KindPlain, '0, '0));
    send_item(control_item(FuncRead));
    // zero limit acts as one; maximum time expires every dated record
    set_config(4'd0, TimeMax, 1'b0);
    send_item(control_item(FuncClear));
    send_item(offer_item(16'h0202, 8'd9, 8'd0, 1'b0, KindPlain, '0, '0));
    send_item(offer_item(16'h0203, 8'd3, 8'd0, 1'b0, KindPlain, '0, 40'd5));
    send_item(offer_item(16'h0204, 8'd50, 8'd0, 1'b0, KindPlain, '0, '0));
    send_item(control_item(FuncRead));
  endtask

  task automatic test_backpressure();
    record_t r;
    set_config(4'd8, T0, 1'b0);
    tx_idle   = 1'b0;
    hold_left = 150;
    for (int i = 0; i < 22; i++) begin
      r = offer_item(16'($urandom()), 8'($urandom_range(1, 255)), 8'($urandom()),
                     1'b0, KindPlain, '0, '0);
      if (i == 8 || i == 21) r.func = FuncRead;
      send_item(r);
    end
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    record_t     r;
    int          sent;
    logic [3:0]  lim;
    logic [39:0] now;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin lim = 4'd8;  now = '0;          end
        1:       begin lim = 4'd1;  now = rand_time(); end
        2:       begin lim = 4'd15; now = rand_time(); end
        3:       begin lim = 4'd3;  now = rand_time(); end
        4:       begin lim = 4'd0;  now = TimeMax;     end
        default: begin lim = 4'($urandom_range(0, 15)); now = rand_time(); end
      endcase
      set_config(lim, now, 1'(p));
      // one phase runs with no stalls on either side
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      sent = 0;
      while (sent < 62) begin
        r = random_record();
        send_item(r);
        if (r.func != FuncUnused) sent++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_ignored();
    test_query_scoring();
    test_limit_changes();
    test_backpressure();
    test_random_traffic();
    drain();
    $display("Sent %0d items (%0d read-outs) across %0d register settings,",
             items_sent, readouts_sent, settings_count);
    $display("checked %0d ranked entries, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/srk_pkg.sv
rtl/srk_front.sv
rtl/srk_queue.sv
rtl/srk_back.sv
rtl/scored_top_k_ranker.sv
verif/tb_top.sv
